// File: rtl/roicm_pkg.sv
// Shared constants and types for the window channel mean block.
package roicm_pkg;

    // Largest image dimension handled; row count wraps after MAX_DIM - 1
    localparam int MAX_DIM  = 4096;
    localparam int CNT_W    = $clog2(MAX_DIM);
    // Wide enough for MAX_DIM up to 16384 and for win_left + window width
    localparam int CMP_W    = 15;

    localparam int IW_W     = 13;
    localparam int OFF_W    = 12;
    localparam int DIM_W    = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 3;

    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int CHI_W    = 2;
    localparam int SUM_W    = 32;

    localparam int SCALE    = 1000;
    localparam int SCALE_W  = 10;
    localparam int PROD_W   = SUM_W + SCALE_W;
    localparam int AREA_W   = 2 * DIM_W;
    localparam int MEAN_W   = 18;
    localparam int MEAN_MAX = 255000;

    // Window size used in place of a zero width or height
    localparam int DIM_ZERO_SUB = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT  = 3'd4;

    localparam logic [IW_W-1:0]  RST_IMAGE_WIDTH = 13'd640;
    localparam logic [DIM_W-1:0] RST_WIN_DIM     = 13'd2;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [AREA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: rtl/roicm_div.sv
// Restoring divider, one quotient bit per cycle.
module roicm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  roicm_pkg::t_div_req i_req,
    output roicm_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(roicm_pkg::PROD_W);

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [roicm_pkg::AREA_W-1:0]    r_rem;
    logic [roicm_pkg::PROD_W-1:0]    r_quo;
    logic [roicm_pkg::AREA_W-1:0]    r_dvs;

    logic [roicm_pkg::AREA_W:0]      w_trial;
    logic                            w_ge;

    assign w_trial = {r_rem, r_quo[roicm_pkg::PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // flag the step that produces the last quotient bit
            r_done <= r_busy && !i_req.start && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(roicm_pkg::PROD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            // shift in next dividend bit, subtract when it fits
            r_rem <= w_ge ? roicm_pkg::AREA_W'(w_trial - {1'b0, r_dvs})
                          : w_trial[roicm_pkg::AREA_W-1:0];
            r_quo <= {r_quo[roicm_pkg::PROD_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/roi_channel_mean_top.sv
// Top level: per-channel mean over a rectangular window of an RGB frame.
//
//  channel        direction  payload (low bit first)
//  s_axis_*       in         tdata: red[7:0] green[15:8] blue[23:16]; tlast: frame_end
//  m_axis_*       out        tdata: mean_red[17:0] mean_green[35:18] mean_blue[53:36]
//  i_cfg_*        in         idx 0..4: image_width win_left win_top win_width win_height
//
// Pixels are taken one per cycle while the block accumulates.
// The frame-end pixel starts the mean pass: one area multiply, then per channel
// a scale multiply, a divider start and PROD_W (42) divider steps on the single
// shared bit-serial divider. Input is held off meanwhile.
// The result waits in an output register; a new frame may start while it is unread.
// Reset (synchronous, active low) clears counters, sums and handshakes; registers
// return to 640, 0, 0, 2, 2.
module roi_channel_mean_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,   // red, green, blue
    input  logic                             s_axis_tlast,   // frame_end
    // means out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [55:0]                      m_axis_tdata,   // mean_red, mean_green, mean_blue
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [roicm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [roicm_pkg::CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_ACC,
        S_AREA,
        S_MUL,
        S_START,
        S_WAIT,
        S_LOAD
    } t_state;

    t_state r_state;

    // configuration
    logic [roicm_pkg::IW_W-1:0]  r_image_width;
    logic [roicm_pkg::OFF_W-1:0] r_win_left;
    logic [roicm_pkg::OFF_W-1:0] r_win_top;
    logic [roicm_pkg::DIM_W-1:0] r_win_width;
    logic [roicm_pkg::DIM_W-1:0] r_win_height;

    // frame state
    logic [roicm_pkg::CNT_W-1:0] r_col;
    logic [roicm_pkg::CNT_W-1:0] r_row;
    logic [roicm_pkg::SUM_W-1:0] r_sum [roicm_pkg::NUM_CH];

    // mean pass
    logic [roicm_pkg::CHI_W-1:0]  r_ch;
    logic [roicm_pkg::PROD_W-1:0] r_prod;
    logic [roicm_pkg::AREA_W-1:0] r_area;
    logic [roicm_pkg::MEAN_W-1:0] r_res [roicm_pkg::NUM_CH];

    // output register
    logic                         r_m_valid;
    logic [roicm_pkg::MEAN_W-1:0] r_m_mean [roicm_pkg::NUM_CH];

    logic                         w_in_acc;
    logic                         w_last_acc;
    logic [roicm_pkg::CMP_W-1:0]  w_iw;
    logic [roicm_pkg::DIM_W-1:0]  w_ww;
    logic [roicm_pkg::DIM_W-1:0]  w_wh;
    logic [roicm_pkg::CMP_W-1:0]  w_col;
    logic [roicm_pkg::CMP_W-1:0]  w_row;
    logic                         w_in_win;
    logic                         w_row_end;
    logic [roicm_pkg::CNT_W-1:0]  w_row_next;
    logic [roicm_pkg::CH_W-1:0]   w_pix [roicm_pkg::NUM_CH];
    logic [roicm_pkg::SUM_W-1:0]  w_sum_next [roicm_pkg::NUM_CH];
    logic [roicm_pkg::SUM_W-1:0]  w_sum_sel;
    logic [roicm_pkg::MEAN_W-1:0] w_mean;
    logic                         w_out_free;

    roicm_pkg::t_div_req w_div_req;
    roicm_pkg::t_div_rsp w_div_rsp;

    // hold input off during reset as well, so no item is taken and dropped
    assign s_axis_tready = (r_state == S_ACC) && i_rst_n;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_last_acc    = w_in_acc && s_axis_tlast;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // effective image width and window size
    assign w_iw = (r_image_width == '0 ||
                   roicm_pkg::CMP_W'(r_image_width) > roicm_pkg::CMP_W'(roicm_pkg::MAX_DIM))
                  ? roicm_pkg::CMP_W'(roicm_pkg::MAX_DIM)
                  : roicm_pkg::CMP_W'(r_image_width);
    assign w_ww = (r_win_width == '0)  ? roicm_pkg::DIM_W'(roicm_pkg::DIM_ZERO_SUB)
                                       : r_win_width;
    assign w_wh = (r_win_height == '0) ? roicm_pkg::DIM_W'(roicm_pkg::DIM_ZERO_SUB)
                                       : r_win_height;

    assign w_col = roicm_pkg::CMP_W'(r_col);
    assign w_row = roicm_pkg::CMP_W'(r_row);

    assign w_in_win = (w_col >= roicm_pkg::CMP_W'(r_win_left)) &&
                      (w_col <  roicm_pkg::CMP_W'(r_win_left) + roicm_pkg::CMP_W'(w_ww)) &&
                      (w_row >= roicm_pkg::CMP_W'(r_win_top)) &&
                      (w_row <  roicm_pkg::CMP_W'(r_win_top) + roicm_pkg::CMP_W'(w_wh));

    assign w_row_end  = (w_col + 1'b1 >= w_iw);
    assign w_row_next = (w_row + 1'b1 >= roicm_pkg::CMP_W'(roicm_pkg::MAX_DIM))
                        ? '0 : r_row + 1'b1;

    assign w_pix[0] = s_axis_tdata[7:0];
    assign w_pix[1] = s_axis_tdata[15:8];
    assign w_pix[2] = s_axis_tdata[23:16];

    // saturating channel sums
    always_comb begin
        logic [roicm_pkg::SUM_W:0] v_add;
        for (int i = 0; i < roicm_pkg::NUM_CH; i++) begin
            v_add = {1'b0, r_sum[i]} + (roicm_pkg::SUM_W + 1)'(w_pix[i]);
            w_sum_next[i] = v_add[roicm_pkg::SUM_W] ? '1 : v_add[roicm_pkg::SUM_W-1:0];
        end
    end

    always_comb begin
        case (r_ch)
            2'd0:    w_sum_sel = r_sum[0];
            2'd1:    w_sum_sel = r_sum[1];
            default: w_sum_sel = r_sum[2];
        endcase
    end

    // clamp the quotient to the top of the mean range
    assign w_mean = (w_div_rsp.quotient > roicm_pkg::PROD_W'(roicm_pkg::MEAN_MAX))
                    ? roicm_pkg::MEAN_W'(roicm_pkg::MEAN_MAX)
                    : w_div_rsp.quotient[roicm_pkg::MEAN_W-1:0];

    assign w_div_req.start    = (r_state == S_START);
    assign w_div_req.dividend = r_prod;
    assign w_div_req.divisor  = r_area;

    roicm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= roicm_pkg::RST_IMAGE_WIDTH;
            r_win_left    <= '0;
            r_win_top     <= '0;
            r_win_width   <= roicm_pkg::RST_WIN_DIM;
            r_win_height  <= roicm_pkg::RST_WIN_DIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                roicm_pkg::CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                roicm_pkg::CFG_WIN_LEFT:    r_win_left    <= i_cfg_data[roicm_pkg::OFF_W-1:0];
                roicm_pkg::CFG_WIN_TOP:     r_win_top     <= i_cfg_data[roicm_pkg::OFF_W-1:0];
                roicm_pkg::CFG_WIN_WIDTH:   r_win_width   <= i_cfg_data;
                roicm_pkg::CFG_WIN_HEIGHT:  r_win_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, frame state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACC;
            r_col     <= '0;
            r_row     <= '0;
            r_ch      <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < roicm_pkg::NUM_CH; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            // drop the taken result unless the load below refills the register
            if (r_m_valid && m_axis_tready && r_state != S_LOAD) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_ACC: begin
                    if (w_in_acc) begin
                        if (w_in_win) begin
                            for (int i = 0; i < roicm_pkg::NUM_CH; i++) begin
                                r_sum[i] <= w_sum_next[i];
                            end
                        end
                        // the frame-end pixel leaves the position at zero
                        if (s_axis_tlast) begin
                            r_col   <= '0;
                            r_row   <= '0;
                            r_ch    <= '0;
                            r_state <= S_AREA;
                        end else if (w_row_end) begin
                            r_col <= '0;
                            r_row <= w_row_next;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_AREA:  r_state <= S_MUL;
                S_MUL:   r_state <= S_START;
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_div_rsp.done) begin
                        if (r_ch == roicm_pkg::CHI_W'(roicm_pkg::NUM_CH - 1)) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_LOAD: begin
                    // hold until the output register is free, then clear the sums
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        for (int i = 0; i < roicm_pkg::NUM_CH; i++) begin
                            r_sum[i] <= '0;
                        end
                        r_state <= S_ACC;
                    end
                end
                default: r_state <= S_ACC;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_AREA) begin
            r_area <= roicm_pkg::AREA_W'(w_ww) * roicm_pkg::AREA_W'(w_wh);
        end
        if (r_state == S_MUL) begin
            r_prod <= roicm_pkg::PROD_W'(w_sum_sel) *
                      roicm_pkg::PROD_W'(roicm_pkg::SCALE);
        end
        if (r_state == S_WAIT && w_div_rsp.done) begin
            r_res[r_ch] <= w_mean;
        end
        if (r_state == S_LOAD && w_out_free) begin
            for (int i = 0; i < roicm_pkg::NUM_CH; i++) begin
                r_m_mean[i] <= r_res[i];
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_mean[2], r_m_mean[1], r_m_mean[0]};

    // the frame-end pixel starts the mean pass with the position cleared
    a_last_starts_pass : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_acc |=> (r_state == S_AREA) && (r_col == '0) && (r_row == '0))
        else $error("frame end did not start the mean pass");

    // divider finishes only while the sequencer waits on it
    a_div_done_in_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_WAIT))
        else $error("divider result outside wait state");

    // a fresh result is always within the mean range
    a_mean_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
            (r_m_mean[0] <= roicm_pkg::MEAN_W'(roicm_pkg::MEAN_MAX)) &&
            (r_m_mean[1] <= roicm_pkg::MEAN_W'(roicm_pkg::MEAN_MAX)) &&
            (r_m_mean[2] <= roicm_pkg::MEAN_W'(roicm_pkg::MEAN_MAX)))
        else $error("mean above range");

    // sums are cleared once a result is loaded
    a_sums_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && w_out_free) |=>
            (r_sum[0] == '0) && (r_sum[1] == '0) && (r_sum[2] == '0))
        else $error("sums not cleared after result");

endmodule

// File: tb/sv/roi_channel_mean_top_test.sv
// Self-checking testbench for the window channel mean block: pixel stream in, channel means out.
module roi_channel_mean_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Idle time after the last mean arrives, with margin over one mean pass
    localparam int MEAN_PASS_CYCLES = 160;
    // Long receiver hold-off, longer than two mean passes so the block fills up
    localparam int HOLD_CYCLES      = 600;
    localparam int RANDOM_PHASES    = 12;
    localparam int PHASE_ITEMS      = 110;

    typedef struct packed {
        logic [roicm_pkg::MEAN_W-1:0] red;
        logic [roicm_pkg::MEAN_W-1:0] green;
        logic [roicm_pkg::MEAN_W-1:0] blue;
    } t_channel_means;

    // Note for one directed pixel: when typed is set, the means are written out by hand
    typedef struct packed {
        logic           typed;
        t_channel_means means;
    } t_typed_note;

    typedef struct packed {
        logic [roicm_pkg::CH_W-1:0]   red;
        logic [roicm_pkg::CH_W-1:0]   green;
        logic [roicm_pkg::CH_W-1:0]   blue;
        logic                         frame_end;
        logic                         typed;
        logic [roicm_pkg::MEAN_W-1:0] mean_red;
        logic [roicm_pkg::MEAN_W-1:0] mean_green;
        logic [roicm_pkg::MEAN_W-1:0] mean_blue;
    } t_pixel_row;

    // Directed pixels under the reset window (columns 0-1, rows 0-1 of a 640 wide image,
    // so the divisor is 4). Means are typed in where they follow at a glance.
    localparam int DIRECTED_ROWS = 10;
    localparam t_pixel_row DIRECTED [DIRECTED_ROWS] = '{
        '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0, 18'd0,      18'd0,      18'd0},
        '{8'd1,   8'd255, 8'd127, 1'b1, 1'b1, 18'd64000,  18'd63750,  18'd63750},
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 18'd0,      18'd0,      18'd0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 18'd63750,  18'd63750,  18'd63750},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 18'd0,      18'd0,      18'd0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 18'd127500, 18'd127500, 18'd127500},
        '{8'hAA,  8'h55,  8'hF0,  1'b0, 1'b0, 18'd0,      18'd0,      18'd0},
        '{8'h55,  8'hAA,  8'h0F,  1'b0, 1'b0, 18'd0,      18'd0,      18'd0},
        '{8'h80,  8'h01,  8'hFF,  1'b1, 1'b0, 18'd0,      18'd0,      18'd0},
        '{8'h7F,  8'hFE,  8'h01,  1'b1, 1'b0, 18'd0,      18'd0,      18'd0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [23:0]                     s_axis_tdata = '0;   // red, green, blue
    logic                            s_axis_tlast = 1'b0; // frame_end
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [55:0]                     m_axis_tdata;        // mean_red, mean_green, mean_blue
    logic                            i_cfg_we = 1'b0;
    logic [roicm_pkg::CFG_IDX_W-1:0] i_cfg_idx = roicm_pkg::CFG_IMAGE_WIDTH;
    logic [roicm_pkg::CFG_W-1:0]     i_cfg_data = '0;

    roi_channel_mean_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Generous limit: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Mean predictor: own copy of the window registers and the frame state
    // ---------------------------------------------------------------------
    logic [roicm_pkg::IW_W-1:0]  cfg_image_width = roicm_pkg::RST_IMAGE_WIDTH;
    logic [roicm_pkg::OFF_W-1:0] cfg_win_left = '0;
    logic [roicm_pkg::OFF_W-1:0] cfg_win_top = '0;
    logic [roicm_pkg::DIM_W-1:0] cfg_win_width = roicm_pkg::RST_WIN_DIM;
    logic [roicm_pkg::DIM_W-1:0] cfg_win_height = roicm_pkg::RST_WIN_DIM;

    int unsigned                 frame_col = 0;
    int unsigned                 frame_row = 0;
    logic [roicm_pkg::SUM_W-1:0] sum_red = '0;
    logic [roicm_pkg::SUM_W-1:0] sum_green = '0;
    logic [roicm_pkg::SUM_W-1:0] sum_blue = '0;

    t_channel_means   pending_means [$];
    t_typed_note      typed_q [$];

    int unsigned      fault_count = 0;
    int unsigned      pixels_accepted = 0;
    int unsigned      frames_checked = 0;
    int unsigned      settings_used = 0;

    // Image widths of 0 or above MAX_DIM count as MAX_DIM
    function automatic int unsigned eff_image_width(int unsigned iw);
        return (iw == 0 || iw > roicm_pkg::MAX_DIM) ? roicm_pkg::MAX_DIM : iw;
    endfunction

    function automatic int unsigned eff_win_dim(int unsigned d);
        return (d == 0) ? roicm_pkg::DIM_ZERO_SUB : d;
    endfunction

    function automatic logic [roicm_pkg::SUM_W-1:0] sat_sum(
            logic [roicm_pkg::SUM_W-1:0] acc, logic [roicm_pkg::CH_W-1:0] v);
        logic [roicm_pkg::SUM_W:0] t;
        t = {1'b0, acc} + v;
        return t[roicm_pkg::SUM_W] ? '1 : t[roicm_pkg::SUM_W-1:0];
    endfunction

    function automatic logic [roicm_pkg::MEAN_W-1:0] scaled_mean(
            logic [roicm_pkg::SUM_W-1:0] sum, longint unsigned area);
        longint unsigned m;
        m = sum;
        m = (m * roicm_pkg::SCALE) / area;
        return (m > roicm_pkg::MEAN_MAX) ? roicm_pkg::MEAN_W'(roicm_pkg::MEAN_MAX)
                                         : roicm_pkg::MEAN_W'(m);
    endfunction

    // Count one pixel; on frame end produce the three means and clear the frame
    task automatic accumulate_pixel(input logic [roicm_pkg::CH_W-1:0] r,
                                    input logic [roicm_pkg::CH_W-1:0] g,
                                    input logic [roicm_pkg::CH_W-1:0] b, input logic last,
                                    output logic produced, output t_channel_means means);
        int unsigned     iw;
        int unsigned     ww;
        int unsigned     wh;
        longint unsigned area;
        iw = eff_image_width(cfg_image_width);
        ww = eff_win_dim(cfg_win_width);
        wh = eff_win_dim(cfg_win_height);
        if (frame_col >= cfg_win_left && frame_col < cfg_win_left + ww &&
            frame_row >= cfg_win_top && frame_row < cfg_win_top + wh) begin
            sum_red   = sat_sum(sum_red, r);
            sum_green = sat_sum(sum_green, g);
            sum_blue  = sat_sum(sum_blue, b);
        end
        if (frame_col + 1 >= iw) begin
            frame_col = 0;
            frame_row = (frame_row + 1 >= roicm_pkg::MAX_DIM) ? 0 : frame_row + 1;
        end else begin
            frame_col = frame_col + 1;
        end
        produced = last;
        means    = '0;
        if (last) begin
            area        = longint'(ww) * longint'(wh);
            means.red   = scaled_mean(sum_red, area);
            means.green = scaled_mean(sum_green, area);
            means.blue  = scaled_mean(sum_blue, area);
            frame_col   = 0;
            frame_row   = 0;
            sum_red     = '0;
            sum_green   = '0;
            sum_blue    = '0;
        end
    endtask

    // Check every accepted result, predict on every accepted pixel, then track register writes
    always @(posedge i_clk) begin : frame_watch
        t_channel_means got;
        t_channel_means want;
        t_channel_means predicted;
        t_typed_note    note;
        logic           produced;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.red   = m_axis_tdata[roicm_pkg::MEAN_W-1:0];
                got.green = m_axis_tdata[2*roicm_pkg::MEAN_W-1:roicm_pkg::MEAN_W];
                got.blue  = m_axis_tdata[3*roicm_pkg::MEAN_W-1:2*roicm_pkg::MEAN_W];
                if (pending_means.size() == 0) begin
                    $error("mean result with none expected: red %0d green %0d blue %0d",
                           got.red, got.green, got.blue);
                    fault_count++;
                end else begin
                    want = pending_means.pop_front();
                    frames_checked++;
                    if (got.red !== want.red) begin
                        $error("mean_red: expected %0d, got %0d", want.red, got.red);
                        fault_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("mean_green: expected %0d, got %0d", want.green, got.green);
                        fault_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("mean_blue: expected %0d, got %0d", want.blue, got.blue);
                        fault_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pixels_accepted++;
                accumulate_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                                 s_axis_tlast, produced, predicted);
                note = '0;
                if (typed_q.size() != 0)
                    note = typed_q.pop_front();
                if (produced)
                    pending_means.push_back(note.typed ? note.means : predicted);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    roicm_pkg::CFG_IMAGE_WIDTH:
                        cfg_image_width = i_cfg_data[roicm_pkg::IW_W-1:0];
                    roicm_pkg::CFG_WIN_LEFT:
                        cfg_win_left    = i_cfg_data[roicm_pkg::OFF_W-1:0];
                    roicm_pkg::CFG_WIN_TOP:
                        cfg_win_top     = i_cfg_data[roicm_pkg::OFF_W-1:0];
                    roicm_pkg::CFG_WIN_WIDTH:
                        cfg_win_width   = i_cfg_data[roicm_pkg::DIM_W-1:0];
                    roicm_pkg::CFG_WIN_HEIGHT:
                        cfg_win_height  = i_cfg_data[roicm_pkg::DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------------
    int rx_stall_pct = 0;
    int tx_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    int unsigned cur_iw = roicm_pkg::RST_IMAGE_WIDTH; // effective image width in force
    int unsigned frame_left = 0;                      // pixels still to send in the open frame

    // Offer one item and hold it until the block takes it
    task automatic send_pixel(input logic [roicm_pkg::CH_W-1:0] r,
                              input logic [roicm_pkg::CH_W-1:0] g,
                              input logic [roicm_pkg::CH_W-1:0] b, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [roicm_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[roicm_pkg::CFG_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_window(input int unsigned iw, input int unsigned left,
                              input int unsigned top, input int unsigned w,
                              input int unsigned h);
        write_reg(roicm_pkg::CFG_IMAGE_WIDTH, iw);
        write_reg(roicm_pkg::CFG_WIN_LEFT, left);
        write_reg(roicm_pkg::CFG_WIN_TOP, top);
        write_reg(roicm_pkg::CFG_WIN_WIDTH, w);
        write_reg(roicm_pkg::CFG_WIN_HEIGHT, h);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_iw = eff_image_width(iw);
        settings_used++;
    endtask

    // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
    task automatic set_idling(input int mode);
        tx_idle_pct  <= (mode == 1) ? 45 : (mode == 3) ? 25 : 0;
        rx_stall_pct <= (mode == 2) ? 45 : (mode == 3) ? 25 : 0;
    endtask

    // Drop valid, wait for every mean to arrive, then let a mean pass worth of cycles go by
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge i_clk);
        repeat (MEAN_PASS_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [roicm_pkg::CH_W-1:0] pick_byte();
        logic [roicm_pkg::CH_W-1:0] v;
        v = $urandom;
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // Mostly whole rows, so the window rows are reached; some short or ragged frames
    function automatic int unsigned pick_frame_len(input bit short_frames);
        int unsigned len;
        if (short_frames)
            return $urandom_range(1, 3);
        if ($urandom_range(4) == 0)
            return $urandom_range(1, 8);
        len = cur_iw * $urandom_range(1, 12);
        if ($urandom_range(2) == 0)
            len = len + $urandom_range(1, 2);
        if (len > 400)
            len = $urandom_range(1, 400);
        return len;
    endfunction

    // Stream random pixels; a frame left open carries over into the next setting
    task automatic stream_pixels(input int unsigned count, input bit short_frames);
        for (int unsigned i = 0; i < count; i++) begin
            if (frame_left == 0)
                frame_left = pick_frame_len(short_frames);
            send_pixel(pick_byte(), pick_byte(), pick_byte(), frame_left == 1);
            frame_left--;
            while ($urandom_range(99) < tx_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic send_long_frame(input int unsigned len, input bit full_scale);
        for (int unsigned i = 0; i < len; i++) begin
            if (full_scale)
                send_pixel('1, '1, '1, i == len - 1);
            else
                send_pixel(pick_byte(), pick_byte(), pick_byte(), i == len - 1);
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        t_typed_note note;
        int unsigned kind;
        int unsigned iw;
        int unsigned span;
        int unsigned left;
        int unsigned top;
        int unsigned w;
        int unsigned h;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels under the reset registers, no idling
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            note.typed       = DIRECTED[i].typed;
            note.means.red   = DIRECTED[i].mean_red;
            note.means.green = DIRECTED[i].mean_green;
            note.means.blue  = DIRECTED[i].mean_blue;
            typed_q.push_back(note);
            send_pixel(DIRECTED[i].red, DIRECTED[i].green, DIRECTED[i].blue,
                       DIRECTED[i].frame_end);
        end
        wait_idle();

        // Full-scale pixels over the whole window: means at the top of the range
        set_window(4, 0, 0, 4, 4);
        send_long_frame(16, 1'b1);
        wait_idle();

        // Window hanging past the right edge, column wrap into the next rows
        set_window(16, 10, 0, 8, 2);
        send_long_frame(40, 1'b0);
        wait_idle();

        // Extreme settings with random frames
        set_idling(1);
        set_window(1, 0, 0, 1, 1);
        stream_pixels(40, 1'b0);
        wait_idle();
        set_idling(2);
        set_window(0, 0, 0, 0, 0);
        stream_pixels(30, 1'b0);
        wait_idle();
        set_idling(3);
        set_window(8191, 4095, 4095, 4096, 4096);
        stream_pixels(30, 1'b0);
        wait_idle();
        set_idling(0);
        set_window(3, 2, 1, 4, 3);
        stream_pixels(40, 1'b0);
        wait_idle();

        // Hold the receiver off while the sender keeps offering short frames
        set_window(2, 0, 0, 2, 1);
        set_idling(0);
        hold_req <= hold_req + 1;
        stream_pixels(60, 1'b1);
        wait_idle();

        // Random settings, cycling through the idling patterns
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            kind = $urandom_range(19);
            if (kind < 14)
                iw = $urandom_range(1, 16);
            else if (kind < 17)
                iw = $urandom_range(17, 64);
            else if (kind == 17)
                iw = 0;
            else if (kind == 18)
                iw = $urandom_range(roicm_pkg::MAX_DIM + 1, 8191);
            else
                iw = $urandom_range(0, 8191);
            span = eff_image_width(iw);
            if (span > 64)
                span = 64;
            left = ($urandom_range(7) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, span + 1);
            top  = ($urandom_range(7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 6);
            w    = ($urandom_range(7) == 0) ? $urandom_range(0, 4096)
                                            : $urandom_range(0, span + 1);
            h    = ($urandom_range(7) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 6);
            set_idling(p % 4);
            set_window(iw, left, top, w, h);
            stream_pixels(PHASE_ITEMS, 1'b0);
            wait_idle();
        end

        $display("covered %0d pixels and %0d frame means over %0d window settings",
                 pixels_accepted, frames_checked, settings_used);
        $display("incl. zero-size and off-image windows, full-scale means and a long hold-off");
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
